// ===== rtl/sirdx_pkg.sv =====
package sirdx_pkg;

  // fixed field widths
  localparam int INPUT_W     = 32;
  localparam int SYMBOL_W    = 8;
  localparam int RADIX_W     = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int SYMS_PER_REG = CFG_DATA_W / SYMBOL_W;

  // reciprocal divider
  localparam int DIV_W       = 32;
  localparam int RECIP_W     = 33;
  localparam int SHIFT_BASE  = 33;
  localparam int SHIFT_OFF_W = 3;
  localparam int MAX_RADIX   = 32;
  localparam int MIN_RADIX   = 2;

  localparam logic [SYMBOL_W-1:0] MINUS_SIGN = 8'h2D;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RADIX = 3'd0,
    REG_SYM0  = 3'd1,
    REG_SYM1  = 3'd2,
    REG_SYM2  = 3'd3,
    REG_SYM3  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [RADIX_W-1:0]     radix;
    logic [RECIP_W-1:0]     recip;
    logic [SHIFT_OFF_W-1:0] roff;
  } div_cfg_t;

  localparam logic [39:0] P33 = 40'd1 << 33;
  localparam logic [39:0] P34 = 40'd1 << 34;
  localparam logic [39:0] P35 = 40'd1 << 35;
  localparam logic [39:0] P36 = 40'd1 << 36;
  localparam logic [39:0] P37 = 40'd1 << 37;

  // ceil(2^(32+l) / d), l = ceil(log2 d); entries below two repeat radix two
  localparam logic [RECIP_W-1:0] RECIP_TABLE [0:MAX_RADIX] = '{
    RECIP_W'((P33 + 40'd1) / 40'd2),
    RECIP_W'((P33 + 40'd1) / 40'd2),
    RECIP_W'((P33 + 40'd1) / 40'd2),
    RECIP_W'((P34 + 40'd2) / 40'd3),
    RECIP_W'((P34 + 40'd3) / 40'd4),
    RECIP_W'((P35 + 40'd4) / 40'd5),
    RECIP_W'((P35 + 40'd5) / 40'd6),
    RECIP_W'((P35 + 40'd6) / 40'd7),
    RECIP_W'((P35 + 40'd7) / 40'd8),
    RECIP_W'((P36 + 40'd8) / 40'd9),
    RECIP_W'((P36 + 40'd9) / 40'd10),
    RECIP_W'((P36 + 40'd10) / 40'd11),
    RECIP_W'((P36 + 40'd11) / 40'd12),
    RECIP_W'((P36 + 40'd12) / 40'd13),
    RECIP_W'((P36 + 40'd13) / 40'd14),
    RECIP_W'((P36 + 40'd14) / 40'd15),
    RECIP_W'((P36 + 40'd15) / 40'd16),
    RECIP_W'((P37 + 40'd16) / 40'd17),
    RECIP_W'((P37 + 40'd17) / 40'd18),
    RECIP_W'((P37 + 40'd18) / 40'd19),
    RECIP_W'((P37 + 40'd19) / 40'd20),
    RECIP_W'((P37 + 40'd20) / 40'd21),
    RECIP_W'((P37 + 40'd21) / 40'd22),
    RECIP_W'((P37 + 40'd22) / 40'd23),
    RECIP_W'((P37 + 40'd23) / 40'd24),
    RECIP_W'((P37 + 40'd24) / 40'd25),
    RECIP_W'((P37 + 40'd25) / 40'd26),
    RECIP_W'((P37 + 40'd26) / 40'd27),
    RECIP_W'((P37 + 40'd27) / 40'd28),
    RECIP_W'((P37 + 40'd28) / 40'd29),
    RECIP_W'((P37 + 40'd29) / 40'd30),
    RECIP_W'((P37 + 40'd30) / 40'd31),
    RECIP_W'((P37 + 40'd31) / 40'd32)
  };

  // extra right shift beyond SHIFT_BASE, l - 1
  localparam logic [SHIFT_OFF_W-1:0] SHIFT_TABLE [0:MAX_RADIX] = '{
    3'd0, 3'd0, 3'd0,
    3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

endpackage

// ===== rtl/sirdx_ifs.sv =====
interface sirdx_num_if;
  import sirdx_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [INPUT_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface sirdx_sym_if;
  import sirdx_pkg::*;

  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

// ===== rtl/sirdx_front.sv =====
module sirdx_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  sirdx_num_if.sink             numbers,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic                  q_neg,
  output logic [VALUE_BITS-1:0] q_mag
);
  import sirdx_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0] raw;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  push;
  logic                  pop;
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  neg_q [DEPTH];
  logic [VALUE_BITS-1:0] mag_q [DEPTH];

  // sign and magnitude; the most negative value wraps to 2^(VALUE_BITS-1)
  assign raw = numbers.number[VALUE_BITS-1:0];
  assign neg = raw[VALUE_BITS-1];
  assign mag = neg ? (~raw + VALUE_BITS'(1)) : raw;

  assign numbers.ready = (count != CNT_W'(DEPTH));
  assign push    = numbers.valid && numbers.ready;
  assign q_valid = (count != '0);
  assign pop     = q_valid && q_ready;
  assign q_neg   = neg_q[rd_ptr];
  assign q_mag   = mag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      neg_q[wr_ptr] <= neg;
      mag_q[wr_ptr] <= mag;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

// ===== rtl/sirdx_back.sv =====
module sirdx_back #(
  parameter int MAX_SYMBOLS = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  output logic                                    q_ready,
  input  logic                                    q_neg,
  input  logic [VALUE_BITS-1:0]                   q_mag,
  input  sirdx_pkg::div_cfg_t                     dcfg,
  input  logic [MAX_SYMBOLS*sirdx_pkg::SYMBOL_W-1:0] alphabet,
  sirdx_sym_if.source                             text
);
  import sirdx_pkg::*;

  localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int IDX_W   = $clog2(VALUE_BITS);
  localparam int PROD_W  = DIV_W + RECIP_W;
  localparam int QR_W    = DIV_W + RADIX_W;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUB, S_SIGN, S_EMIT} state_t;

  state_t              state;
  logic                neg;
  logic [DIV_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;
  logic [CNT_W-1:0]    cnt;
  logic [DIGIT_W-1:0]  digits [VALUE_BITS];
  logic                out_valid;
  logic [SYMBOL_W-1:0] out_symbol;
  logic                out_last;

  logic [DIV_W-1:0]    quo;
  logic [QR_W-1:0]     qr;
  logic [DIV_W-1:0]    rem_full;
  logic                out_free;
  logic                emit;
  logic [CNT_W-1:0]    idx;
  logic [DIGIT_W-1:0]  sym_digit;
  logic [SYMBOL_W-1:0] sym_byte;

  // quotient from the registered reciprocal product, remainder by back-multiply
  assign quo      = DIV_W'((prod >> SHIFT_BASE) >> dcfg.roff);
  assign qr       = QR_W'(quo) * QR_W'(dcfg.radix);
  assign rem_full = mag - qr[DIV_W-1:0];

  assign out_free  = !out_valid || text.ready;
  assign emit      = out_free && ((state == S_SIGN) || (state == S_EMIT));
  assign idx       = cnt - CNT_W'(1);
  assign sym_digit = digits[idx[IDX_W-1:0]];
  assign sym_byte  = alphabet[sym_digit*SYMBOL_W +: SYMBOL_W];

  assign q_ready     = (state == S_IDLE);
  assign text.valid  = out_valid;
  assign text.symbol = out_symbol;
  assign text.last   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            neg   <= q_neg;
            mag   <= DIV_W'(q_mag);
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(mag) * PROD_W'(dcfg.recip);
          state <= S_SUB;
        end
        S_SUB: begin
          digits[cnt[IDX_W-1:0]] <= rem_full[DIGIT_W-1:0];
          cnt <= cnt + CNT_W'(1);
          mag <= quo;
          if (quo == '0) begin
            state <= neg ? S_SIGN : S_EMIT;
          end else begin
            state <= S_MUL;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_symbol <= MINUS_SIGN;
            out_last   <= 1'b0;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_symbol <= sym_byte;
            out_last   <= (idx == '0);
            cnt        <= idx;
            if (idx == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> (rem_full < DIV_W'(dcfg.radix)))
    else $error("digit remainder not below radix");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |-> (qr <= QR_W'(mag)))
    else $error("quotient too large for magnitude");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(VALUE_BITS))
    else $error("digit count above value width");

endmodule

// ===== rtl/signed_int_to_radix_digits.sv =====
// signed integer to text in a configurable radix
//
// numbers: one beat per signed value (field number, low VALUE_BITS bits used)
// text:    one beat per output symbol, most significant digit first, a minus
//          sign ahead of negative values, last set on the final symbol
// cfg:     plain write port, cfg_index 0 = radix (clamped to 2..MAX_SYMBOLS),
//          1..4 = alphabet bytes 0-7, 8-15, 16-23, 24-31; other indexes ignored
//
// timing: a value is picked up from the queue, then each of its digits takes
// a reciprocal multiply step and a remainder step; a negative value then
// sends its minus sign, and the digits follow, one per symbol beat; the
// sign and each digit wait while the output register holds a stalled beat
// the first symbol is registered once digit generation ends and the
// output register is free
// a two-entry queue between the sign/magnitude front and the digit engine
// keeps the numbers channel taking beats while the engine is busy
// when text is stalled the output register holds its beat and the engine
// waits; nothing is dropped
// reset: synchronous, clears control state, radix back to 2, alphabet all zero
module signed_int_to_radix_digits #(
  parameter int MAX_SYMBOLS = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  sirdx_num_if.sink                           numbers,
  sirdx_sym_if.source                         text,
  input  logic                                cfg_wr_en,
  input  logic [sirdx_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sirdx_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sirdx_pkg::*;

  localparam int ALPHA_W = MAX_SYMBOLS * SYMBOL_W;

  // config state
  div_cfg_t             dcfg;
  logic [ALPHA_W-1:0]   alphabet;

  // radix field of the write data and its clamped value
  logic [RADIX_W-1:0]   wr_radix;
  logic [RADIX_W-1:0]   clamp_radix;

  // front to back queue side
  logic                  q_valid;
  logic                  q_ready;
  logic                  q_neg;
  logic [VALUE_BITS-1:0] q_mag;

  assign wr_radix = cfg_data[RADIX_W-1:0];

  always_comb begin
    priority if (wr_radix < RADIX_W'(MIN_RADIX)) begin
      clamp_radix = RADIX_W'(MIN_RADIX);
    end else if (wr_radix > RADIX_W'(MAX_SYMBOLS)) begin
      clamp_radix = RADIX_W'(MAX_SYMBOLS);
    end else begin
      clamp_radix = wr_radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcfg.radix <= RADIX_W'(MIN_RADIX);
      dcfg.recip <= RECIP_TABLE[MIN_RADIX];
      dcfg.roff  <= SHIFT_TABLE[MIN_RADIX];
      alphabet   <= '0;
    end else if (cfg_wr_en) begin
      // radix write also loads the reciprocal and shift for the divider
      if (cfg_index == REG_RADIX) begin
        dcfg.radix <= clamp_radix;
        dcfg.recip <= RECIP_TABLE[clamp_radix];
        dcfg.roff  <= SHIFT_TABLE[clamp_radix];
      end
      // symbol k lives in register REG_SYM0 + k/8, byte k%8
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
        if (cfg_index == CFG_INDEX_W'(int'(REG_SYM0) + j / SYMS_PER_REG)) begin
          alphabet[j*SYMBOL_W +: SYMBOL_W] <=
            cfg_data[(j % SYMS_PER_REG)*SYMBOL_W +: SYMBOL_W];
        end
      end
    end
  end

  // sign/magnitude split and input queue
  sirdx_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .numbers (numbers),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_neg   (q_neg),
    .q_mag   (q_mag)
  );

  // digit engine and symbol output register
  sirdx_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_neg    (q_neg),
    .q_mag    (q_mag),
    .dcfg     (dcfg),
    .alphabet (alphabet),
    .text     (text)
  );

endmodule
